FILE: hdl/m6502_pkg.sv
// Package for the partial 6502 execute unit: decode types, codes and decode function.
// No dependencies.
package m6502_pkg;

  localparam int unsigned MemDepthDefault = 65536;

  typedef enum logic [2:0] {
    K_LDA, K_LDX, K_LDY, K_ADC, K_AND, K_ASL, K_BR, K_BIT
  } kind_e;

  typedef enum logic [3:0] {
    M_IMM, M_ZP, M_ZPX, M_ZPY, M_ABS, M_ABX, M_ABY, M_INX, M_INY, M_ACC, M_REL
  } amode_e;

  localparam logic [1:0] ModeWrite = 2'd0;
  localparam logic [1:0] ModeExec  = 2'd1;
  localparam logic [1:0] ModeReset = 2'd2;

  localparam logic [7:0] StatusReset = 8'b0001_0000;
  localparam logic [7:0] SpReset     = 8'hFF;
  localparam logic [15:0] VecLo      = 16'hFFFC;
  localparam logic [15:0] VecHi      = 16'hFFFD;

  // memory port commands from the controller
  typedef enum logic [2:0] {
    SRC_OPND, SRC_OPND1, SRC_PTR, SRC_PTR1, SRC_EA, SRC_VLO, SRC_VHI, SRC_WADDR
  } asrc_e;

  typedef struct packed {
    logic   rd_en;
    asrc_e  rd_src;
    logic   ld_lo;    // capture read byte into low byte latch
    logic   ld_hi;    // capture read byte into high byte latch
    logic   ld_zp;    // capture zero-page pointer
    logic   ld_op;    // capture operand/data byte
    logic   ea_fix;   // form effective address from latches
    logic   exec;     // commit the instruction
    logic   wb;       // write ASL result back
    logic   wr_item;  // mode 0 write
    logic   rst_core; // mode 2 register load
    logic   done;     // present result
    logic   unsup;
  } cmd_t;

  typedef struct packed {
    logic   valid;
    kind_e  kind;
    amode_e am;
  } dec_t;

  function automatic dec_t decode(input logic [7:0] op);
    dec_t d;
    d = '{valid: 1'b1, kind: K_LDA, am: M_IMM};
    case (op)
      8'hA9: d = '{1'b1, K_LDA, M_IMM};
      8'hA5: d = '{1'b1, K_LDA, M_ZP};
      8'hB5: d = '{1'b1, K_LDA, M_ZPX};
      8'hAD: d = '{1'b1, K_LDA, M_ABS};
      8'hBD: d = '{1'b1, K_LDA, M_ABX};
      8'hB9: d = '{1'b1, K_LDA, M_ABY};
      8'hA1: d = '{1'b1, K_LDA, M_INX};
      8'hB1: d = '{1'b1, K_LDA, M_INY};
      8'hA2: d = '{1'b1, K_LDX, M_IMM};
      8'hA6: d = '{1'b1, K_LDX, M_ZP};
      8'hB6: d = '{1'b1, K_LDX, M_ZPY};
      8'hAE: d = '{1'b1, K_LDX, M_ABS};
      8'hBE: d = '{1'b1, K_LDX, M_ABY};
      8'hA0: d = '{1'b1, K_LDY, M_IMM};
      8'hA4: d = '{1'b1, K_LDY, M_ZP};
      8'hB4: d = '{1'b1, K_LDY, M_ZPX};
      8'hAC: d = '{1'b1, K_LDY, M_ABS};
      8'hBC: d = '{1'b1, K_LDY, M_ABX};
      8'h69: d = '{1'b1, K_ADC, M_IMM};
      8'h65: d = '{1'b1, K_ADC, M_ZP};
      8'h75: d = '{1'b1, K_ADC, M_ZPX};
      8'h6D: d = '{1'b1, K_ADC, M_ABS};
      8'h7D: d = '{1'b1, K_ADC, M_ABX};
      8'h79: d = '{1'b1, K_ADC, M_ABY};
      8'h61: d = '{1'b1, K_ADC, M_INX};
      8'h71: d = '{1'b1, K_ADC, M_INY};
      8'h29: d = '{1'b1, K_AND, M_IMM};
      8'h25: d = '{1'b1, K_AND, M_ZP};
      8'h35: d = '{1'b1, K_AND, M_ZPX};
      8'h2D: d = '{1'b1, K_AND, M_ABS};
      8'h3D: d = '{1'b1, K_AND, M_ABX};
      8'h39: d = '{1'b1, K_AND, M_ABY};
      8'h21: d = '{1'b1, K_AND, M_INX};
      8'h31: d = '{1'b1, K_AND, M_INY};
      8'h0A: d = '{1'b1, K_ASL, M_ACC};
      8'h06: d = '{1'b1, K_ASL, M_ZP};
      8'h16: d = '{1'b1, K_ASL, M_ZPX};
      8'h0E: d = '{1'b1, K_ASL, M_ABS};
      8'h1E: d = '{1'b1, K_ASL, M_ABX};
      8'h90, 8'hB0, 8'hF0, 8'h30, 8'hD0, 8'h10: d = '{1'b1, K_BR, M_REL};
      8'h24: d = '{1'b1, K_BIT, M_ZP};
      8'h2C: d = '{1'b1, K_BIT, M_ABS};
      default: d.valid = 1'b0;
    endcase
    return d;
  endfunction

endpackage

FILE: hdl/mos6502_partial_execute_unit_core.sv
// Top level of the partial 6502 execute unit: sequencer plus datapath.
// Depends on m6502_pkg, m6502_ctrl, m6502_dp.
//
//  channel  | handshake          | payload
//  command  | start_i / busy_o   | mode_i opcode_i write_address_i write_data_i
//  result   | done_o (one cycle) | acc_out_o xreg_out_o yreg_out_o status_out_o
//           |                    | pc_out_o sp_out_o unsupported_o
//
// Each beat steps through its memory reads one at a time over the single memory read port.
// After reset a clearing pass writes zero to every memory location; busy_o is high meanwhile.
// The receiver cannot stall; each result shows for one cycle with done_o.
module mos6502_partial_execute_unit_core import m6502_pkg::*; #(
  parameter int unsigned MemDepth = MemDepthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  mode_i,
  input  logic [7:0]  opcode_i,
  input  logic [15:0] write_address_i,
  input  logic [7:0]  write_data_i,
  output logic        done_o,
  output logic [7:0]  acc_out_o,
  output logic [7:0]  xreg_out_o,
  output logic [7:0]  yreg_out_o,
  output logic [7:0]  status_out_o,
  output logic [15:0] pc_out_o,
  output logic [7:0]  sp_out_o,
  output logic        unsupported_o
);

  cmd_t cmd;
  dec_t dec;
  logic clr_done, acc;

  assign acc = start_i && !busy_o;

  m6502_ctrl u_ctrl (
    .clk_i, .rst_ni, .start_i(acc), .mode_i, .opcode_i,
    .clr_done_i(clr_done), .busy_o, .cmd_o(cmd), .dec_o(dec)
  );

  m6502_dp #(.MemDepth(MemDepth)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .dec_i(dec), .opcode_i,
    .write_address_i, .write_data_i, .start_i(acc), .clr_done_o(clr_done),
    .acc_o(acc_out_o), .xreg_o(xreg_out_o), .yreg_o(yreg_out_o),
    .status_o(status_out_o), .pc_o(pc_out_o), .sp_o(sp_out_o)
  );

  assign done_o        = cmd.done;
  assign unsupported_o = cmd.unsup;

`ifndef ASSERT_OFF
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy_o) else $error("result outside a busy window");
  a_one_action: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones({cmd.exec, cmd.rst_core, cmd.wr_item}) <= 1)
    else $error("two state updates at once");
  a_no_accept_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !clr_done |-> busy_o) else $error("beat accepted during clearing pass");
`endif

endmodule

FILE: hdl/m6502_ctrl.sv
// Sequencer for the partial 6502 execute unit: steps memory reads per addressing mode.
// Depends on m6502_pkg.
module m6502_ctrl import m6502_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  logic [1:0] mode_i,
  input  logic [7:0] opcode_i,
  input  logic       clr_done_i,
  output logic       busy_o,
  output cmd_t       cmd_o,
  output dec_t       dec_o
);

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_OPND  = 4'd2;
  localparam logic [3:0] S_OPND1 = 4'd3;
  localparam logic [3:0] S_PTR   = 4'd4;
  localparam logic [3:0] S_PTR1  = 4'd5;
  localparam logic [3:0] S_EAFIX = 4'd6;
  localparam logic [3:0] S_DATA  = 4'd7;
  localparam logic [3:0] S_EXEC  = 4'd8;
  localparam logic [3:0] S_VHI   = 4'd9;
  localparam logic [3:0] S_RST   = 4'd10;
  localparam logic [3:0] S_DONE  = 4'd11;
  localparam logic [3:0] S_WAIT  = 4'd12;

  logic [3:0] state_q, state_d;
  dec_t       dec_q, dec_d;
  dec_t       dn;

  assign dn     = decode(opcode_i);
  assign busy_o = (state_q != S_IDLE);
  assign dec_o  = dec_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      dec_q   <= '{1'b0, K_LDA, M_IMM};
    end else begin
      state_q <= state_d;
      dec_q   <= dec_d;
    end
  end

  always_comb begin
    state_d = state_q;
    dec_d   = dec_q;
    cmd_o   = '0;
    cmd_o.rd_src = SRC_OPND;
    case (state_q)
      S_CLEAR: if (clr_done_i) state_d = S_IDLE;
      S_IDLE: begin
        if (start_i) begin
          dec_d = dn;
          case (mode_i)
            ModeWrite: begin
              cmd_o.wr_item = 1'b1;
              state_d = S_DONE;
            end
            ModeExec: begin
              if (!dn.valid) state_d = S_DONE;
              else if (dn.am == M_ACC) state_d = S_EXEC;
              else begin
                cmd_o.rd_en = 1'b1;
                cmd_o.rd_src = SRC_OPND;
                state_d = S_OPND;
              end
            end
            ModeReset: begin
              cmd_o.rd_en = 1'b1;
              cmd_o.rd_src = SRC_VLO;
              state_d = S_VHI;
            end
            default: state_d = S_DONE;
          endcase
        end
      end
      S_OPND: begin
        // first operand byte is on the read port
        case (dec_q.am)
          M_IMM, M_REL: begin
            cmd_o.ld_op = 1'b1;
            state_d = S_EXEC;
          end
          M_ABS, M_ABX, M_ABY: begin
            cmd_o.ld_lo = 1'b1;
            cmd_o.rd_en = 1'b1;
            cmd_o.rd_src = SRC_OPND1;
            state_d = S_OPND1;
          end
          M_INX, M_INY: begin
            cmd_o.ld_zp = 1'b1;
            state_d = S_PTR;
          end
          default: begin
            cmd_o.ld_lo = 1'b1;
            state_d = S_EAFIX;
          end
        endcase
      end
      S_OPND1: begin
        cmd_o.ld_hi = 1'b1;
        state_d = S_EAFIX;
      end
      S_PTR: begin
        cmd_o.rd_en = 1'b1;
        cmd_o.rd_src = SRC_PTR;
        state_d = S_PTR1;
      end
      S_PTR1: begin
        cmd_o.ld_lo = 1'b1;
        cmd_o.rd_en = 1'b1;
        cmd_o.rd_src = SRC_PTR1;
        state_d = S_OPND1;
      end
      S_EAFIX: begin
        cmd_o.ea_fix = 1'b1;
        state_d = S_DATA;
      end
      S_DATA: begin
        cmd_o.rd_en = 1'b1;
        cmd_o.rd_src = SRC_EA;
        state_d = S_WAIT;
      end
      S_WAIT: begin
        cmd_o.ld_op = 1'b1;
        state_d = S_EXEC;
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        cmd_o.wb = (dec_q.kind == K_ASL) && (dec_q.am != M_ACC);
        state_d = S_DONE;
      end
      S_VHI: begin
        cmd_o.ld_lo = 1'b1;
        cmd_o.rd_en = 1'b1;
        cmd_o.rd_src = SRC_VHI;
        state_d = S_RST;
      end
      S_RST: begin
        cmd_o.ld_hi = 1'b1;
        cmd_o.rst_core = 1'b1;
        state_d = S_DONE;
      end
      S_DONE: begin
        cmd_o.done = 1'b1;
        cmd_o.unsup = !dec_q.valid;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
    // mode other than execute never flags unsupported
    if (state_q == S_IDLE && start_i && mode_i != ModeExec) dec_d.valid = 1'b1;
  end

endmodule

FILE: hdl/m6502_dp.sv
// Datapath for the partial 6502 execute unit: registers, memory, ALU.
// Depends on m6502_pkg.
module m6502_dp import m6502_pkg::*; #(
  parameter int unsigned MemDepth = MemDepthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cmd_t        cmd_i,
  input  dec_t        dec_i,
  input  logic [7:0]  opcode_i,
  input  logic [15:0] write_address_i,
  input  logic [7:0]  write_data_i,
  input  logic        start_i,
  output logic        clr_done_o,
  output logic [7:0]  acc_o,
  output logic [7:0]  xreg_o,
  output logic [7:0]  yreg_o,
  output logic [7:0]  status_o,
  output logic [15:0] pc_o,
  output logic [7:0]  sp_o
);

  localparam int unsigned AW = $clog2(MemDepth);

  logic [7:0]  mem_q [MemDepth];
  logic [7:0]  rdata_q;
  logic [7:0]  a_q, x_q, y_q, p_q, sp_q;
  logic [15:0] pc_q;
  logic [7:0]  lo_q, hi_q, zp_q, op_q;
  logic [15:0] ea_q, wa_q;
  logic [7:0]  opc_q;
  logic [AW:0] clr_q;
  logic        clr_busy;

  assign clr_busy   = !clr_q[AW];
  assign clr_done_o = clr_q[AW];

  logic [15:0] raddr, pc1;
  assign pc1 = pc_q + 16'd1;

  always_comb begin
    case (cmd_i.rd_src)
      SRC_OPND:  raddr = pc1;
      SRC_OPND1: raddr = pc_q + 16'd2;
      SRC_PTR:   raddr = {8'h00, zp_q};
      SRC_PTR1:  raddr = {8'h00, zp_q + 8'd1};
      SRC_EA:    raddr = ea_q;
      SRC_VLO:   raddr = VecLo;
      SRC_VHI:   raddr = VecHi;
      default:   raddr = wa_q;
    endcase
  end

  // ALU
  logic [8:0] sum;
  logic [7:0] res, asl_m;
  logic       do_write;
  logic [AW-1:0] waddr;
  logic [7:0]    wdata;
  assign sum   = {1'b0, a_q} + {1'b0, op_q} + {8'd0, p_q[0]};
  assign asl_m = (dec_i.am == M_ACC) ? a_q : op_q;
  assign res   = {asl_m[6:0], 1'b0};

  always_comb begin
    do_write = 1'b0;
    waddr    = ea_q[AW-1:0];
    wdata    = res;
    if (clr_busy) begin
      do_write = 1'b1;
      waddr    = clr_q[AW-1:0];
      wdata    = 8'h00;
    end else if (cmd_i.wr_item) begin
      do_write = 1'b1;
      waddr    = write_address_i[AW-1:0];
      wdata    = write_data_i;
    end else if (cmd_i.wb) begin
      do_write = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_write) mem_q[waddr] <= wdata;
    if (cmd_i.rd_en) rdata_q <= mem_q[raddr[AW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) clr_q <= '0;
    else if (clr_busy) clr_q <= clr_q + 1'b1;
  end

  // operand latches
  always_ff @(posedge clk_i) begin
    if (start_i) opc_q <= opcode_i;
    if (cmd_i.ld_lo) lo_q <= rdata_q;
    if (cmd_i.ld_hi) hi_q <= rdata_q;
    if (cmd_i.ld_op) op_q <= rdata_q;
    if (cmd_i.ld_zp) begin
      zp_q <= (dec_i.am == M_INX) ? rdata_q + x_q : rdata_q;
    end
    if (cmd_i.ea_fix) begin
      case (dec_i.am)
        M_ZP:    ea_q <= {8'h00, lo_q};
        M_ZPX:   ea_q <= {8'h00, lo_q + x_q};
        M_ZPY:   ea_q <= {8'h00, lo_q + y_q};
        M_ABX:   ea_q <= {hi_q, lo_q} + {8'h00, x_q};
        M_ABY,
        M_INY:   ea_q <= {hi_q, lo_q} + {8'h00, y_q};
        default: ea_q <= {hi_q, lo_q};
      endcase
    end
    wa_q <= write_address_i;
  end

  logic taken;
  always_comb begin
    case (opc_q)
      8'h90:   taken = !p_q[0];
      8'hB0:   taken = p_q[0];
      8'hF0:   taken = p_q[1];
      8'hD0:   taken = !p_q[1];
      8'h30:   taken = p_q[7];
      default: taken = !p_q[7];
    endcase
  end

  logic [15:0] pc_adv;
  always_comb begin
    case (dec_i.am)
      M_ACC:             pc_adv = pc1;
      M_ABS, M_ABX, M_ABY: pc_adv = pc_q + 16'd3;
      default:           pc_adv = pc_q + 16'd2;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_q <= '0; x_q <= '0; y_q <= '0;
      p_q <= StatusReset; sp_q <= SpReset; pc_q <= '0;
    end else if (cmd_i.rst_core) begin
      a_q <= '0; x_q <= '0; y_q <= '0;
      p_q <= StatusReset; sp_q <= SpReset; pc_q <= {rdata_q, lo_q};
    end else if (cmd_i.exec) begin
      pc_q <= pc_adv;
      case (dec_i.kind)
        K_LDA: begin
          a_q <= op_q; p_q[7] <= op_q[7]; p_q[1] <= (op_q == 8'h00);
        end
        K_LDX: begin
          x_q <= op_q; p_q[7] <= op_q[7]; p_q[1] <= (op_q == 8'h00);
        end
        K_LDY: begin
          y_q <= op_q; p_q[7] <= op_q[7]; p_q[1] <= (op_q == 8'h00);
        end
        K_ADC: begin
          a_q <= sum[7:0];
          p_q[0] <= sum[8];
          p_q[6] <= (a_q[7] ^ sum[7]) & (op_q[7] ^ sum[7]);
          p_q[7] <= sum[7];
          p_q[1] <= (sum[7:0] == 8'h00);
        end
        K_AND: begin
          a_q <= a_q & op_q;
          p_q[7] <= a_q[7] & op_q[7];
          p_q[1] <= ((a_q & op_q) == 8'h00);
        end
        K_ASL: begin
          if (dec_i.am == M_ACC) a_q <= res;
          p_q[0] <= asl_m[7]; p_q[7] <= res[7]; p_q[1] <= (res == 8'h00);
        end
        K_BR: begin
          if (taken) pc_q <= pc_adv + {{8{op_q[7]}}, op_q};
        end
        default: begin
          p_q[7] <= op_q[7]; p_q[6] <= op_q[6];
          p_q[1] <= ((a_q & op_q) == 8'h00);
        end
      endcase
    end
  end

  assign acc_o = a_q;
  assign xreg_o = x_q;
  assign yreg_o = y_q;
  assign status_o = p_q;
  assign pc_o = pc_q;
  assign sp_o = sp_q;

endmodule
